[design/rdpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdpr_pkg
// Types, codes and helpers shared by the debug-link packet receiver.
// ----------------------------------------------------------------------------
package rdpr_pkg;

   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_INTR   = 8'h03;
   localparam logic [7:0] CH_DETACH = 8'h04;
   localparam logic [7:0] CH_START  = 8'h24;  // '$'
   localparam logic [7:0] CH_END    = 8'h23;  // '#'
   localparam logic [7:0] CH_ESC    = 8'h7D;  // '}'
   localparam logic [7:0] ESC_MASK  = 8'h20;
   localparam logic [7:0] CH_ACK    = 8'h2B;  // '+'
   localparam logic [7:0] CH_NAK    = 8'h2D;  // '-'

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_INTR   = 3'd1;
   localparam logic [2:0] EV_DETACH = 3'd2;
   localparam logic [2:0] EV_ACCEPT = 3'd3;
   localparam logic [2:0] EV_REJECT = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PENDING = 3'd1,
      PH_ESCAPE  = 3'd2,
      PH_CS0     = 3'd3,
      PH_CS1     = 3'd4
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic [2:0] event_res;
      logic [8:0] packet_length;
      logic       overflowed;
      logic [7:0] read_data;
   } rsp_type;

   function automatic logic [3:0] hex_value(input logic [7:0] ch);
      logic [3:0] v;
      v = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = ch[3:0];
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         v = ch[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

[design/rdpr_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdpr_parser
// Link byte state machine: events, escapes, checksum and store writes.
// ----------------------------------------------------------------------------
module rdpr_parser
   import rdpr_pkg::*;
#(
   parameter int  PAYLOAD_DEPTH = 256,
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           item,
   output rsp_type                rsp,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data
);

   localparam int POS_W = $clog2(PAYLOAD_DEPTH + 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       hi_ff, hi_in;
   logic             ovf_ff, ovf_in;

   logic             room;
   logic [7:0]       rx_sum;
   logic [7:0]       c;
   logic [POS_W+8:0] pos_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         sum_ff   <= '0;
         hi_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         hi_ff    <= hi_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign c       = item.rx_byte;
   assign room    = pos_ff < POS_W'(PAYLOAD_DEPTH);
   assign rx_sum  = {hi_ff, hex_value(c)};
   assign pos_ext = {9'd0, pos_ff};
   assign wr_addr = pos_ff[ADDR_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hi_in    = hi_ff;
      ovf_in   = ovf_ff;
      wr_en    = 1'b0;
      wr_data  = c;
      rsp      = '0;
      if (accept && item.op == OP_RX) begin
         unique case (phase_ff)
            PH_IDLE: begin
               priority if (c == CH_INTR) begin
                  rsp.send_valid = 1'b1;
                  rsp.send_byte  = CH_ACK;
                  rsp.event_res  = EV_INTR;
               end else if (c == CH_DETACH) begin
                  rsp.send_valid = 1'b1;
                  rsp.send_byte  = CH_ACK;
                  rsp.event_res  = EV_DETACH;
               end else if (c == CH_START) begin
                  pos_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  phase_in = PH_PENDING;
               end else begin
               end
            end
            PH_PENDING: begin
               if (c == CH_END) begin
                  phase_in = PH_CS0;
               end else begin
                  sum_in = sum_ff + c;
                  if (c == CH_ESC) begin
                     phase_in = PH_ESCAPE;
                  end else if (room) begin
                     wr_en  = 1'b1;
                     pos_in = pos_ff + POS_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            PH_ESCAPE: begin
               sum_in   = sum_ff + c;
               wr_data  = c ^ ESC_MASK;
               phase_in = PH_PENDING;
               if (room) begin
                  wr_en  = 1'b1;
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            PH_CS0: begin
               hi_in    = hex_value(c);
               phase_in = PH_CS1;
            end
            PH_CS1: begin
               rsp.send_valid = 1'b1;
               rsp.overflowed = ovf_ff;
               if (rx_sum == sum_ff) begin
                  rsp.send_byte     = CH_ACK;
                  rsp.event_res     = EV_ACCEPT;
                  rsp.packet_length = pos_ext[8:0];
               end else begin
                  rsp.send_byte = CH_NAK;
                  rsp.event_res = EV_REJECT;
               end
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[design/rdpr_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdpr_store
// Payload memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdpr_store #(
   parameter int  PAYLOAD_DEPTH = 256,
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [PAYLOAD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/rdpr_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdpr_out_fifo
// Two-entry result queue between the result register and the output port.
// ----------------------------------------------------------------------------
module rdpr_out_fifo
   import rdpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_item,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_item,
   output logic [1:0]   level
);

   rsp_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = count_ff != 2'd0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ in_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, in_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

[design/remote_debug_packet_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Results pass the s1 result register and then the output queue to rsp_.
// Throughput: one item per cycle while req_ready is high, with one parser
// update and one payload memory access (write or read) per item.
// Reset: synchronous; clears parser phase, counters, flags and output queue.
// The payload store is not cleared; entries read before written are undefined.
// ----------------------------------------------------------------------------
// remote_debug_packet_receiver_core
// Debug-link packet receiver: parser, payload store, result register, queue.
// ----------------------------------------------------------------------------
module remote_debug_packet_receiver_core
   import rdpr_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

   logic              accept;
   rsp_type           parse_rsp;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W+7:0] idx_ext;
   logic              in_range;
   logic [7:0]        rd_data;

   logic              s1_valid_ff;
   rsp_type           s1_rsp_ff;
   logic              s1_read_ff;
   rsp_type           s1_out;
   logic [1:0]        level;

   assign req_ready = ({1'b0, level} + {2'b00, s1_valid_ff} < 3'd2) || (rsp_valid && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign idx_ext   = {{ADDR_W{1'b0}}, req_item.read_index};
   assign in_range  = 32'(req_item.read_index) < 32'(PAYLOAD_DEPTH);
   assign rd_en     = accept && req_item.op == OP_READ;

   rdpr_parser #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_item),
      .rsp     (parse_rsp),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   rdpr_store #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff  <= parse_rsp;
         s1_read_ff <= rd_en && in_range;
      end
   end

   always_comb begin
      s1_out           = s1_rsp_ff;
      s1_out.read_data = s1_read_ff ? rd_data : 8'd0;
   end

   rdpr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_item   (s1_out),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item),
      .level     (level)
   );

endmodule
`default_nettype wire
